// ===== hw/rtl/qxmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared types, widths and helpers for the quad-X motor mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned InW       = 16;
  localparam int unsigned SumW      = 22;
  localparam int unsigned PulseW    = 12;
  localparam int unsigned MinW      = 11;
  localparam int unsigned ArmW      = 11;
  localparam int unsigned MaxW      = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned FracW     = 4;

  localparam logic [MinW-1:0] MinPulseRst = MinW'(1000);
  localparam logic [ArmW-1:0] ArmPulseRst = ArmW'(1200);
  localparam logic [MaxW-1:0] MaxPulseRst = MaxW'(1300);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_PULSE = 2'd0,
    REG_ARM_SPIN  = 2'd1,
    REG_MAX_PULSE = 2'd2
  } reg_idx_e;

  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    logic [MinW-1:0] min_pulse;
    logic [ArmW-1:0] arm_pulse;
    logic [MaxW-1:0] max_pulse;
  } cfg_t;

  typedef struct packed {
    sum_t [NumMotors-1:0] motor;
    sum_t                 mx;
    sum_t                 mn;
    logic [InW-1:0]       base;
  } mix_t;

  // Q18.4 to whole units, half away from zero
  function automatic sum_t round_q4(sum_t v);
    sum_t mag;
    sum_t rnd;
    mag = v[SumW-1] ? -v : v;
    rnd = (mag + sum_t'(8)) >>> FracW;
    return v[SumW-1] ? -rnd : rnd;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qxmm_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qxmm_cfg
// Pulse limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module qxmm_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [qxmm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [qxmm_pkg::CfgDataW-1:0]  cfg_data_i,
  output qxmm_pkg::cfg_t                      cfg_o
);
  import qxmm_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_PULSE: cfg_d.min_pulse = cfg_data_i[MinW-1:0];
        REG_ARM_SPIN:  cfg_d.arm_pulse = cfg_data_i[ArmW-1:0];
        REG_MAX_PULSE: cfg_d.max_pulse = cfg_data_i[MaxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse <= MinPulseRst;
      cfg_q.arm_pulse <= ArmPulseRst;
      cfg_q.max_pulse <= MaxPulseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/qxmm_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qxmm_mix
// Quad-X motor sums with their maximum and minimum.
// ----------------------------------------------------------------------------
module qxmm_mix (
  input  wire logic [qxmm_pkg::InW-1:0]        base_i,
  input  wire logic signed [qxmm_pkg::InW-1:0] roll_i,
  input  wire logic signed [qxmm_pkg::InW-1:0] pitch_i,
  input  wire logic signed [qxmm_pkg::InW-1:0] yaw_i,
  output qxmm_pkg::mix_t                       mix_o
);
  import qxmm_pkg::*;

  sum_t b, r, p, y;
  sum_t mx01, mx23, mn01, mn23;
  sum_t [NumMotors-1:0] m;

  assign b = sum_t'($signed({1'b0, base_i}));
  assign r = sum_t'(roll_i);
  assign p = sum_t'(pitch_i);
  assign y = sum_t'(yaw_i);

  assign m[0] = b + r + p - y;
  assign m[1] = b - r + p + y;
  assign m[2] = b - r - p - y;
  assign m[3] = b + r - p + y;

  assign mx01 = (m[1] > m[0]) ? m[1] : m[0];
  assign mx23 = (m[3] > m[2]) ? m[3] : m[2];
  assign mn01 = (m[1] < m[0]) ? m[1] : m[0];
  assign mn23 = (m[3] < m[2]) ? m[3] : m[2];

  assign mix_o.motor = m;
  assign mix_o.mx    = (mx23 > mx01) ? mx23 : mx01;
  assign mix_o.mn    = (mn23 < mn01) ? mn23 : mn01;
  assign mix_o.base  = base_i;

endmodule
`default_nettype wire

// ===== hw/rtl/qxmm_desat.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qxmm_desat
// Desaturation shifts, rounding to whole microseconds and pulse clamp.
// ----------------------------------------------------------------------------
module qxmm_desat (
  input  wire qxmm_pkg::mix_t                        mix_i,
  input  wire qxmm_pkg::cfg_t                        cfg_i,
  output logic [qxmm_pkg::NumMotors-1:0][qxmm_pkg::PulseW-1:0] pulse_o
);
  import qxmm_pkg::*;

  sum_t maxq, armq, basew, lo, hi, over, under;
  logic do_down, do_up;

  assign maxq  = sum_t'($signed({1'b0, cfg_i.max_pulse, {FracW{1'b0}}}));
  assign armq  = sum_t'($signed({1'b0, cfg_i.arm_pulse, {FracW{1'b0}}}));
  assign lo    = sum_t'($signed({1'b0, cfg_i.min_pulse}));
  assign hi    = sum_t'($signed({1'b0, cfg_i.max_pulse}));
  assign basew = sum_t'($signed({1'b0, mix_i.base}));

  assign do_down = mix_i.mx > maxq;
  assign do_up   = (mix_i.mn < armq) && (basew >= armq);
  assign over    = do_down ? (mix_i.mx - maxq) : '0;
  assign under   = do_up ? (armq - mix_i.mn) : '0;

  for (genvar g = 0; g < NumMotors; g++) begin : g_motor
    sum_t shifted, rounded, clamped;
    assign shifted = mix_i.motor[g] - over + under;
    assign rounded = round_q4(shifted);
    assign clamped = (rounded < lo) ? lo : ((rounded > hi) ? hi : rounded);
    assign pulse_o[g] = clamped[PulseW-1:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/quad_x_motor_mixer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit
// Quad-X motor mixer with attitude-priority desaturation.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_stall_o is low and returns one result
// beat per input beat. A beat passes through the input register, then the
// register after the motor sums and their max/min, then the result register
// after the desaturation, rounding and clamp, which drives out_valid_o.
// Empty stages are filled while the output is stalled, so in_stall_o rises
// only once all three stages hold a beat. The limit registers are written
// through cfg_*; write them only while the unit is empty. cfg_ready_o is
// always high and unknown indexes are ignored.
module quad_x_motor_mixer_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [qxmm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [qxmm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [qxmm_pkg::InW-1:0]        base_throttle_i,
  input  wire logic signed [qxmm_pkg::InW-1:0] roll_correction_i,
  input  wire logic signed [qxmm_pkg::InW-1:0] pitch_correction_i,
  input  wire logic signed [qxmm_pkg::InW-1:0] yaw_correction_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [qxmm_pkg::PulseW-1:0]          motor1_pulse_o,
  output logic [qxmm_pkg::PulseW-1:0]          motor2_pulse_o,
  output logic [qxmm_pkg::PulseW-1:0]          motor3_pulse_o,
  output logic [qxmm_pkg::PulseW-1:0]          motor4_pulse_o
);
  import qxmm_pkg::*;

  cfg_t cfg;

  logic s0_valid_q, s1_valid_q, s2_valid_q;
  logic adv0, adv1, adv2;

  logic [InW-1:0]        base_q;
  logic signed [InW-1:0] roll_q, pitch_q, yaw_q;
  mix_t mix_d, mix_q;
  logic [NumMotors-1:0][PulseW-1:0] pulse_d, pulse_q;

  qxmm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  qxmm_mix u_mix (
    .base_i  (base_q),
    .roll_i  (roll_q),
    .pitch_i (pitch_q),
    .yaw_i   (yaw_q),
    .mix_o   (mix_d)
  );

  qxmm_desat u_desat (
    .mix_i   (mix_q),
    .cfg_i   (cfg),
    .pulse_o (pulse_d)
  );

  // a stage loads when it is empty or its beat moves on
  assign adv2 = !s2_valid_q || !out_stall_i;
  assign adv1 = !s1_valid_q || adv2;
  assign adv0 = !s0_valid_q || adv1;

  assign in_stall_o = !adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv0) s0_valid_q <= in_valid_i;
      if (adv1) s1_valid_q <= s0_valid_q;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      base_q  <= base_throttle_i;
      roll_q  <= roll_correction_i;
      pitch_q <= pitch_correction_i;
      yaw_q   <= yaw_correction_i;
    end
    if (adv1) mix_q   <= mix_d;
    if (adv2) pulse_q <= pulse_d;
  end

  assign out_valid_o    = s2_valid_q;
  assign motor1_pulse_o = pulse_q[0];
  assign motor2_pulse_o = pulse_q[1];
  assign motor3_pulse_o = pulse_q[2];
  assign motor4_pulse_o = pulse_q[3];

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s0_valid_q && s1_valid_q && s2_valid_q))
    else $error("input stalled with an empty stage");

  a_mid_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && adv2) |=> out_valid_o)
    else $error("beat lost between mix and result stage");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !s1_valid_q) |=> !out_valid_o)
    else $error("result beat repeated");

endmodule
`default_nettype wire
